### rtl/ple_pkg.sv
// Shared types and codes for the positional list engine.
`default_nettype none

package ple_pkg;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int POS_W     = 5;
    localparam int IN_VAL_W  = 32;
    localparam int STATUS_W  = 2;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_SEARCH = 2'd2,
        REQ_UPDATE = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_MISS  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    typedef struct packed {
        logic ins;
        logic del;
        logic upd;
        logic load_hit;
        logic shift_hit;
    } t_cell_cmd;

endpackage

`default_nettype wire

### rtl/positional_list_engine.sv
// Top level of the positional list engine: request decode, cell row and result register.
//
// The block keeps an ordered list of up to CAPACITY values in a row of cells, empty after
// reset. Insert, delete and update move the whole row at once: every cell loads its new
// entry from itself, its neighbour or the request in the same clock. In a search all cells
// compare at once, then the match flags move one cell towards the head each cycle while a
// counter tracks the position, so the first match sets the time. A search on an empty list
// answers with a miss without a scan. A finished result sits in an output register, and
// the next request is taken in the same cycle that the result is taken.
`default_nettype none

module positional_list_engine
    import ple_pkg::*;
#(
    parameter int CAPACITY    = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // position [4:0], value_in [36:5], zero padding [39:37]
    input  wire logic [S_TDATA_W-1:0]   s_axis_tdata,
    // req_type [1:0]
    input  wire logic [S_TUSER_W-1:0]   s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // status [1:0], found_position [6:2], list_length [11:7], zero padding [15:12]
    output logic      [M_TDATA_W-1:0]   m_axis_tdata
);

    localparam int LW   = $clog2(CAPACITY + 1);
    localparam int CW   = $clog2(CAPACITY);
    localparam int CMPW = ((LW > POS_W) ? LW : POS_W) + 1;

    t_state               r_state;
    t_state               n_state;
    logic [LW-1:0]        r_len;
    logic [LW-1:0]        n_len;
    logic [LW-1:0]        r_cnt;
    logic [LW-1:0]        n_cnt;
    logic                 r_ovalid;
    logic                 n_ovalid;
    t_status              r_ostatus;
    t_status              n_ostatus;
    logic [POS_W-1:0]     r_ofound;
    logic [POS_W-1:0]     n_ofound;
    logic [POS_W-1:0]     r_olen;
    logic [POS_W-1:0]     n_olen;

    logic                 w_acc;
    t_req                 w_req;
    t_status              w_status;
    t_cell_cmd            w_cmd;
    logic [CMPW-1:0]      w_posx;
    logic [CMPW-1:0]      w_lenx;
    logic [CMPW-1:0]      w_pm1;
    logic [CW-1:0]        w_pidx;
    logic                 w_ins_ok;
    logic                 w_pos_ok;
    logic                 w_full;
    logic [63:0]          w_val64;
    logic [VALUE_WIDTH-1:0] w_val;
    logic [LW-1:0]        w_cnt1;

    logic [VALUE_WIDTH-1:0] w_data [CAPACITY];
    logic                   w_hit  [CAPACITY];

    assign s_axis_tready = (r_state == S_IDLE) && (!r_ovalid || m_axis_tready);
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_req         = t_req'(s_axis_tuser);

    assign w_posx   = CMPW'(s_axis_tdata[POS_W-1:0]);
    assign w_lenx   = CMPW'(r_len);
    assign w_pm1    = w_posx - CMPW'(1);
    assign w_pidx   = w_pm1[CW-1:0];
    assign w_ins_ok = (w_posx != '0) && (w_posx <= w_lenx + CMPW'(1));
    assign w_pos_ok = (w_posx != '0) && (w_posx <= w_lenx);
    assign w_full   = (r_len == LW'(CAPACITY));
    assign w_cnt1   = r_cnt + LW'(1);

    assign w_val64 = {{(64 - IN_VAL_W){s_axis_tdata[POS_W+IN_VAL_W-1]}},
                      s_axis_tdata[POS_W+IN_VAL_W-1:POS_W]};
    assign w_val   = w_val64[VALUE_WIDTH-1:0];

    always_comb begin
        n_state   = r_state;
        n_len     = r_len;
        n_cnt     = r_cnt;
        n_ovalid  = r_ovalid && !m_axis_tready;
        n_ostatus = r_ostatus;
        n_ofound  = r_ofound;
        n_olen    = r_olen;
        w_status  = ST_OK;
        w_cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (w_req)
                        REQ_INSERT: begin
                            if (!w_ins_ok) begin
                                w_status = ST_RANGE;
                            end else if (w_full) begin
                                w_status = ST_FULL;
                            end else begin
                                w_cmd.ins = 1'b1;
                                n_len     = r_len + LW'(1);
                            end
                        end
                        REQ_DELETE: begin
                            if (!w_pos_ok) begin
                                w_status = ST_RANGE;
                            end else begin
                                w_cmd.del = 1'b1;
                                n_len     = r_len - LW'(1);
                            end
                        end
                        REQ_UPDATE: begin
                            if (!w_pos_ok) begin
                                w_status = ST_RANGE;
                            end else begin
                                w_cmd.upd = 1'b1;
                            end
                        end
                        default: begin
                            if (r_len == '0) begin
                                w_status = ST_MISS;
                            end else begin
                                w_cmd.load_hit = 1'b1;
                                n_cnt          = '0;
                                n_state        = S_SCAN;
                            end
                        end
                    endcase
                    if (!w_cmd.load_hit) begin
                        n_ovalid  = 1'b1;
                        n_ostatus = w_status;
                        n_ofound  = '0;
                        n_olen    = POS_W'(n_len);
                    end
                end
            end
            S_SCAN: begin
                if (w_hit[0]) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = ST_OK;
                    n_ofound  = POS_W'(w_cnt1);
                    n_olen    = POS_W'(r_len);
                    n_state   = S_IDLE;
                end else if (w_cnt1 >= r_len) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = ST_MISS;
                    n_ofound  = '0;
                    n_olen    = POS_W'(r_len);
                    n_state   = S_IDLE;
                end else begin
                    w_cmd.shift_hit = 1'b1;
                    n_cnt           = w_cnt1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_len    <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ostatus <= n_ostatus;
        r_ofound  <= n_ofound;
        r_olen    <= n_olen;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] w_prev;
        logic [VALUE_WIDTH-1:0] w_next;
        logic                   w_next_hit;

        if (g == 0) begin : g_head
            assign w_prev = '0;
        end else begin : g_mid
            assign w_prev = w_data[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_next     = '0;
            assign w_next_hit = 1'b0;
        end else begin : g_body
            assign w_next     = w_data[g+1];
            assign w_next_hit = w_hit[g+1];
        end

        ple_cell #(
            .IDX (g),
            .VW  (VALUE_WIDTH),
            .CW  (CW),
            .LW  (LW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (w_cmd),
            .i_pos      (w_pidx),
            .i_val      (w_val),
            .i_len      (r_len),
            .i_prev     (w_prev),
            .i_next     (w_next),
            .i_next_hit (w_next_hit),
            .o_data     (w_data[g]),
            .o_hit      (w_hit[g])
        );
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {{(M_TDATA_W - STATUS_W - 2 * POS_W){1'b0}},
                            r_olen, r_ofound, r_ostatus};

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(CAPACITY))
        else $error("list length above capacity");

    a_scan_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !r_ovalid)
        else $error("result pending while a search is running");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (w_req == REQ_INSERT) && (w_status == ST_OK))
        |=> (r_len == $past(r_len) + LW'(1)))
        else $error("successful insert did not grow the list");

    a_delete_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (w_req == REQ_DELETE) && (w_status == ST_OK))
        |=> (r_len == $past(r_len) - LW'(1)))
        else $error("successful delete did not shrink the list");

endmodule

`default_nettype wire

### rtl/ple_cell.sv
// One list cell: holds a single entry and its search match flag.
`default_nettype none

module ple_cell
    import ple_pkg::*;
#(
    parameter int IDX = 0,
    parameter int VW  = 32,
    parameter int CW  = 4,
    parameter int LW  = 5
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_cell_cmd       i_cmd,
    input  wire logic [CW-1:0]   i_pos,
    input  wire logic [VW-1:0]   i_val,
    input  wire logic [LW-1:0]   i_len,
    input  wire logic [VW-1:0]   i_prev,
    input  wire logic [VW-1:0]   i_next,
    input  wire logic            i_next_hit,
    output logic      [VW-1:0]   o_data,
    output logic                 o_hit
);

    localparam logic [CW-1:0] MY_IDX   = CW'(IDX);
    localparam logic [LW-1:0] MY_IDX_L = LW'(IDX);

    logic [VW-1:0] r_data;
    logic [VW-1:0] n_data;
    logic          r_hit;
    logic          n_hit;

    always_comb begin
        n_data = r_data;
        if (i_cmd.ins) begin
            if (MY_IDX == i_pos) begin
                n_data = i_val;
            end else if (MY_IDX > i_pos) begin
                n_data = i_prev;
            end
        end else if (i_cmd.del) begin
            if (MY_IDX >= i_pos) begin
                n_data = i_next;
            end
        end else if (i_cmd.upd) begin
            if (MY_IDX == i_pos) begin
                n_data = i_val;
            end
        end
    end

    always_comb begin
        n_hit = r_hit;
        if (i_cmd.load_hit) begin
            n_hit = (MY_IDX_L < i_len) && (r_data == i_val);
        end else if (i_cmd.shift_hit) begin
            n_hit = i_next_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= n_hit;
        end
    end

    assign o_data = r_data;
    assign o_hit  = r_hit;

endmodule

`default_nettype wire
